@@ rtl/vrtv_pkg.sv @@
// Package for the vehicle route tour validator: field widths, codes, reset values
// and the check stage record used by the top level.
// No dependencies.
`default_nettype none

package vrtv_pkg;

   // Parameter defaults
   localparam int unsigned MAX_NODES_DEF  = 1024;
   localparam int unsigned DEPOT_NODE_DEF = 0;

   // Field widths
   localparam int NODE_W     = 10;
   localparam int DEMAND_W   = 16;
   localparam int POS_W      = 16;
   localparam int LOAD_W     = 24;
   localparam int COUNT_W    = 11;
   localparam int VERDICT_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Tour tag stored per bitmap entry; tag zero means never visited
   localparam int EPOCH_W = 8;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [DEMAND_W-1:0] demand_type;
   typedef logic [POS_W-1:0]    position_type;
   typedef logic [LOAD_W-1:0]   load_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [EPOCH_W-1:0]  epoch_type;

   localparam epoch_type EPOCH_FIRST = epoch_type'(1);
   localparam epoch_type EPOCH_LAST  = '1;
   localparam epoch_type EPOCH_NONE  = '0;
   localparam load_type  LOAD_MAX    = '1;

   // Configuration reset values
   localparam load_type  CAPACITY_RESET   = '0;
   localparam logic      COMPLETE_RESET   = 1'b1;
   localparam count_type NODE_COUNT_RESET = count_type'(1024);

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_OK         = 3'd0,
      VERDICT_START      = 3'd1,
      VERDICT_CAP        = 3'd2,
      VERDICT_REPEAT     = 3'd3,
      VERDICT_INCOMPLETE = 3'd4
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY_LIMIT   = 2'd0,
      CSR_REQUIRE_COMPLETE = 2'd1,
      CSR_NODE_COUNT       = 2'd2
   } csr_index_type;

   typedef enum logic {
      SWEEP_ACTIVE,
      SWEEP_IDLE
   } sweep_state_type;

   // Transaction held in the check stage while the bitmap read returns
   typedef struct packed {
      node_type     node;
      demand_type   node_demand;
      logic         route_listed;
      position_type listed_position;
      logic         first_item;
      logic         end_of_tour;
      epoch_type    epoch;
      logic         fwd_hit;
   } stage_type;

endpackage

`default_nettype wire

@@ rtl/vrtv_if.sv @@
// Valid/ready channel interfaces for the vehicle route tour validator:
// the node request channel and the verdict response channel. Uses vrtv_pkg.
`default_nettype none

interface vrtv_req_if;
   logic                  valid;
   logic                  ready;
   vrtv_pkg::node_type     node;
   vrtv_pkg::demand_type   node_demand;
   logic                  route_listed;
   vrtv_pkg::position_type listed_position;
   logic                  first_item;
   logic                  end_of_tour;

   modport source (
      output valid, node, node_demand, route_listed, listed_position,
             first_item, end_of_tour,
      input  ready
   );
   modport sink (
      input  valid, node, node_demand, route_listed, listed_position,
             first_item, end_of_tour,
      output ready
   );
endinterface

interface vrtv_rsp_if;
   logic                 valid;
   logic                 ready;
   vrtv_pkg::verdict_type verdict;
   logic                 tour_done;

   modport source (output valid, verdict, tour_done, input ready);
   modport sink   (input valid, verdict, tour_done, output ready);
endinterface

`default_nettype wire

@@ rtl/vehicle_route_tour_validator.sv @@
// Vehicle route tour validator: checks a routing tour streamed one node per transaction.
// Depends on vrtv_pkg and the channel interfaces in vrtv_if.sv.
//
// Usage:
//   req_if carries one tour node per transaction with its demand, the listed route
//   start, and first_item / end_of_tour marks. rsp_if returns one transaction per
//   node: the sticky verdict so far and tour_done (the node's end_of_tour).
//   csr_we / csr_index / csr_wdata write capacity_limit, require_complete and
//   node_count; write them only while the block is idle.
// Pipeline and throughput:
//   An accepted request is registered into the check stage; its result moves to
//   the output register when the check stage fires. One node is accepted per cycle
//   unless a sweep runs or the output stalls; the single bitmap read-modify-write
//   per node, read at acceptance and written in the check stage, sets that rate.
//   Back-to-back hits on one node are covered by forwarding the check stage write.
// Reset and sweeps:
//   After reset the bitmap is swept clear with req_if.ready low.
//   Each tour carries an 8-bit tag; a first_item arriving after 255 tags have been
//   used holds off for a further bitmap sweep before it is accepted.
// Stalls:
//   The result sits in an output register; while rsp_if.ready is low the check
//   stage still takes one more transaction, then req_if.ready drops.
`default_nettype none

module vehicle_route_tour_validator #(
   parameter int unsigned MAX_NODES  = vrtv_pkg::MAX_NODES_DEF,
   parameter int unsigned DEPOT_NODE = vrtv_pkg::DEPOT_NODE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [vrtv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vrtv_pkg::CSR_DATA_W-1:0] csr_wdata,
   vrtv_req_if.sink                            req_if,
   vrtv_rsp_if.source                          rsp_if
);
   import vrtv_pkg::*;

   localparam int              ADDR_W    = $clog2(MAX_NODES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_NODES - 1);
   localparam node_type        DEPOT     = NODE_W'(DEPOT_NODE);

   // Configuration registers
   load_type  capacity_ff;
   logic      complete_ff;
   count_type node_count_ff;

   // Tour state
   load_type     load_ff, load_in;
   count_type    distinct_ff, distinct_in;
   position_type position_ff, position_in;
   verdict_type  verdict_ff, verdict_in;
   epoch_type    epoch_ff;

   // Bitmap memory and its read port
   epoch_type         visited_mem [MAX_NODES];
   epoch_type         rd_tag_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   epoch_type         mem_wdata;

   // Sweep control
   sweep_state_type   sweep_state_ff, sweep_state_in;
   logic [ADDR_W-1:0] sweep_addr_ff;
   logic              sweeping;
   logic              sweep_done;

   // Pipeline
   logic      accept;
   logic      wrap_hit;
   epoch_type req_epoch;
   logic      s1_valid_ff;
   stage_type s1_ff;
   logic      s1_fire;
   logic      mark_write;
   logic [ADDR_W-1:0] s1_addr;

   // Check stage intermediates
   load_type     base_load;
   count_type    base_distinct;
   position_type base_position;
   verdict_type  base_verdict;
   logic         is_depot;
   logic         out_of_range;
   logic         visited;
   logic         mark;
   logic         start_err;
   logic         cap_err;
   logic         repeat_err;
   logic         incomplete_err;
   logic [LOAD_W:0] load_sum;

   // Output register
   logic        rsp_valid_ff;
   verdict_type rsp_verdict_ff;
   logic        rsp_done_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         complete_ff   <= COMPLETE_RESET;
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY_LIMIT:   capacity_ff   <= csr_wdata[LOAD_W-1:0];
            CSR_REQUIRE_COMPLETE: complete_ff   <= csr_wdata[0];
            CSR_NODE_COUNT:       node_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sweep next state
   always_comb begin
      sweep_state_in = sweep_state_ff;
      unique case (sweep_state_ff)
         SWEEP_ACTIVE: begin
            if (sweep_addr_ff == LAST_ADDR) sweep_state_in = SWEEP_IDLE;
         end
         SWEEP_IDLE: begin
            if (wrap_hit && !s1_valid_ff) sweep_state_in = SWEEP_ACTIVE;
         end
         default: sweep_state_in = SWEEP_IDLE;
      endcase
   end

   // Sweep outputs
   always_comb begin
      sweeping   = (sweep_state_ff == SWEEP_ACTIVE);
      sweep_done = sweeping && (sweep_addr_ff == LAST_ADDR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_state_ff <= SWEEP_ACTIVE;
         sweep_addr_ff  <= '0;
      end else begin
         sweep_state_ff <= sweep_state_in;
         if (sweeping) sweep_addr_ff <= sweep_addr_ff + 1'b1;
         else          sweep_addr_ff <= '0;
      end
   end

   // Acceptance; a new tour with no free tag waits for a sweep
   assign wrap_hit      = req_if.valid && req_if.first_item && (epoch_ff == EPOCH_LAST);
   assign s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !sweeping && !wrap_hit && (!s1_valid_ff || s1_fire);
   assign accept        = req_if.valid && req_if.ready;
   assign req_epoch     = req_if.first_item ? epoch_ff + 1'b1 : epoch_ff;
   assign rd_addr       = ADDR_W'(req_if.node);
   assign s1_addr       = ADDR_W'(s1_ff.node);

   // Tour tag
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_FIRST;
      end else if (sweep_done) begin
         epoch_ff <= EPOCH_FIRST;
      end else if (accept) begin
         epoch_ff <= req_epoch;
      end
   end

   // Memory write port: sweep or check stage mark
   assign mark_write = s1_fire && mark;
   always_comb begin
      if (sweeping) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_addr_ff;
         mem_wdata = EPOCH_NONE;
      end else begin
         mem_we    = mark_write;
         mem_waddr = s1_addr;
         mem_wdata = s1_ff.epoch;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) visited_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (accept) rd_tag_ff <= visited_mem[rd_addr];
   end

   // Check stage register; the forward bit covers a mark written in the read cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept || (s1_valid_ff && !s1_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.node            <= req_if.node;
         s1_ff.node_demand     <= req_if.node_demand;
         s1_ff.route_listed    <= req_if.route_listed;
         s1_ff.listed_position <= req_if.listed_position;
         s1_ff.first_item      <= req_if.first_item;
         s1_ff.end_of_tour     <= req_if.end_of_tour;
         s1_ff.epoch           <= req_epoch;
         s1_ff.fwd_hit         <= mark_write && (s1_addr == rd_addr)
                                  && (s1_ff.epoch == req_epoch);
      end
   end

   // Node checks
   always_comb begin
      base_load     = s1_ff.first_item ? '0 : load_ff;
      base_distinct = s1_ff.first_item ? '0 : distinct_ff;
      base_position = s1_ff.first_item ? '0 : position_ff;
      base_verdict  = s1_ff.first_item ? VERDICT_OK : verdict_ff;

      is_depot  = (s1_ff.node == DEPOT);
      start_err = is_depot && s1_ff.route_listed
                  && (s1_ff.listed_position != base_position);
      cap_err   = is_depot && (base_load > capacity_ff);

      // Load closes at the depot, then saturates
      load_sum = {1'b0, (is_depot ? '0 : base_load)}
                 + (LOAD_W + 1)'(s1_ff.node_demand);
      load_in  = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];

      out_of_range = ({1'b0, s1_ff.node} >= node_count_ff)
                     || (32'(s1_ff.node) >= MAX_NODES);
      visited      = (rd_tag_ff == s1_ff.epoch) || s1_ff.fwd_hit;
      repeat_err   = out_of_range || (visited && !is_depot);
      mark         = !out_of_range && !visited;

      distinct_in    = base_distinct + COUNT_W'(mark);
      position_in    = base_position + 1'b1;
      incomplete_err = s1_ff.end_of_tour && complete_ff && (distinct_in != node_count_ff);

      // First error sticks
      if (base_verdict != VERDICT_OK) verdict_in = base_verdict;
      else if (start_err)             verdict_in = VERDICT_START;
      else if (cap_err)               verdict_in = VERDICT_CAP;
      else if (repeat_err)            verdict_in = VERDICT_REPEAT;
      else if (incomplete_err)        verdict_in = VERDICT_INCOMPLETE;
      else                            verdict_in = VERDICT_OK;
   end

   // Tour state update
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff     <= '0;
         distinct_ff <= '0;
         position_ff <= '0;
         verdict_ff  <= VERDICT_OK;
      end else if (s1_fire) begin
         load_ff     <= load_in;
         distinct_ff <= distinct_in;
         position_ff <= position_in;
         verdict_ff  <= verdict_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_verdict_ff <= verdict_in;
         rsp_done_ff    <= s1_ff.end_of_tour;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.verdict   = rsp_verdict_ff;
   assign rsp_if.tour_done = rsp_done_ff;

   // Checks
   a_sticky_verdict: assert property (@(posedge clock) disable iff (reset)
      (verdict_ff != VERDICT_OK) && !(s1_fire && s1_ff.first_item)
      |=> verdict_ff == $past(verdict_ff))
      else $error("sticky verdict changed within a tour");

   a_sweep_drained: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !s1_valid_ff)
      else $error("bitmap sweep overlaps a transaction in the check stage");

   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      32'(distinct_ff) <= MAX_NODES)
      else $error("distinct node count exceeds bitmap depth");

endmodule

`default_nettype wire
